>>> hw/rtl/pk1u_pkg.sv
// ----------------------------------------------------------------------------
// pk1u_pkg: shared constants and types for the type 2 unpadding block
// Sizes, layout constants, register indexes, the cell control struct and the parse status struct.
// ----------------------------------------------------------------------------
package pk1u_pkg;

   localparam int MAX_MESSAGE_BYTES = 64;
   localparam int MAX_EM_BYTES      = 512;

   localparam int BYTE_WIDTH     = 8;
   localparam int EM_LEN_WIDTH   = 10;
   localparam int MSG_LEN_WIDTH  = 7;
   localparam int POS_WIDTH      = 10;
   localparam int CALC_WIDTH     = 12;
   localparam int LEN_WIDTH      = $clog2(MAX_EM_BYTES + 1);
   localparam int CELL_IDX_WIDTH = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
   localparam int COUNT_WIDTH    = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = EM_LEN_WIDTH;

   localparam logic [BYTE_WIDTH-1:0] LEAD_BYTE     = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] BLOCK_TYPE    = 8'h02;
   localparam logic [BYTE_WIDTH-1:0] SEPARATOR     = 8'h00;
   localparam int                    MIN_SEP_INDEX = 10;
   localparam int                    MIN_OVERHEAD  = 11;

   localparam logic [EM_LEN_WIDTH-1:0]  EM_LENGTH_RESET      = 10'd256;
   localparam logic [MSG_LEN_WIDTH-1:0] MESSAGE_LENGTH_RESET = 7'd48;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_EM_LENGTH      = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_MESSAGE_LENGTH = 1'b1;

   typedef struct packed {
      logic load;
      logic shift;
      logic valid;
   } cell_ctrl_type;

   typedef struct packed {
      logic                      final_beat;
      logic                      wr_ok;
      logic [CELL_IDX_WIDTH-1:0] wr_idx;
      logic                      run_valid;
   } parse_status_type;

endpackage

>>> hw/rtl/pk1u_cell.sv
// ----------------------------------------------------------------------------
// pk1u_cell: one message position
// Holds the stored message and fallback byte for its position and one stage
// of the output chain, which loads the chosen byte (or zero for a zero-filled
// position) and shifts toward the port.
module pk1u_cell
   import pk1u_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  wr_en,
   input  logic                  zero_fill,
   input  logic [BYTE_WIDTH-1:0] em_byte,
   input  logic [BYTE_WIDTH-1:0] fallback_byte,
   input  logic [BYTE_WIDTH-1:0] chain_in,
   output logic [BYTE_WIDTH-1:0] chain_out
);

   logic [BYTE_WIDTH-1:0] msg_ff, msg_in;
   logic [BYTE_WIDTH-1:0] fb_ff, fb_in;
   logic [BYTE_WIDTH-1:0] out_ff, out_in;

   always_comb begin
      msg_in = wr_en ? em_byte : msg_ff;
      fb_in  = wr_en ? fallback_byte : fb_ff;
      out_in = out_ff;
      if (ctrl.load) begin
         // the byte written in this same beat is already visible here
         if (zero_fill) begin
            out_in = '0;
         end else begin
            out_in = ctrl.valid ? msg_in : fb_in;
         end
      end else if (ctrl.shift) begin
         out_in = chain_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      fb_ff  <= fb_in;
      out_ff <= out_in;
   end

   assign chain_out = out_ff;

endmodule

>>> hw/rtl/pk1u_ctrl.sv
// ----------------------------------------------------------------------------
// pk1u_ctrl: layout checker
// Tracks the byte position, header bytes and first separator of a run and
// gives the store index, the end of run and the layout verdict for a beat.
// ----------------------------------------------------------------------------
module pk1u_ctrl
   import pk1u_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [BYTE_WIDTH-1:0]    em_byte,
   input  logic [LEN_WIDTH-1:0]     len,
   input  logic [MSG_LEN_WIDTH-1:0] mlen,
   output parse_status_type         status
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 hdr_ok_ff, hdr_ok_in;
   logic                 searching_ff, searching_in;
   logic [POS_WIDTH-1:0] sep_idx_ff, sep_idx_in;
   logic                 sep_found_ff, sep_found_in;

   logic [CALC_WIDTH-1:0] pos_w, len_w, mlen_w, sum_w, idx_w, sep_w;
   logic                  final_beat;

   always_comb begin
      pos_w  = CALC_WIDTH'(pos_ff);
      len_w  = CALC_WIDTH'(len);
      mlen_w = CALC_WIDTH'(mlen);
      sum_w  = pos_w + mlen_w;
      idx_w  = sum_w - len_w;

      hdr_ok_in    = hdr_ok_ff;
      searching_in = searching_ff;
      sep_idx_in   = sep_idx_ff;
      sep_found_in = sep_found_ff;
      if (pos_ff == POS_WIDTH'(0)) begin
         hdr_ok_in = hdr_ok_ff && (em_byte == LEAD_BYTE);
      end else if (pos_ff == POS_WIDTH'(1)) begin
         hdr_ok_in = hdr_ok_ff && (em_byte == BLOCK_TYPE);
      end else if (searching_ff && (em_byte == SEPARATOR)) begin
         sep_idx_in   = pos_ff;
         sep_found_in = 1'b1;
         searching_in = 1'b0;
      end
      sep_w = CALC_WIDTH'(sep_idx_in);

      final_beat = (pos_w + CALC_WIDTH'(1)) >= len_w;

      status.final_beat = final_beat;
      status.wr_ok      = (sum_w >= len_w) && (sum_w < len_w + mlen_w);
      status.wr_idx     = idx_w[CELL_IDX_WIDTH-1:0];
      status.run_valid  = hdr_ok_in && sep_found_in
                       && (sep_w >= CALC_WIDTH'(MIN_SEP_INDEX))
                       && (len_w == sep_w + CALC_WIDTH'(1) + mlen_w)
                       && (len_w >= mlen_w + CALC_WIDTH'(MIN_OVERHEAD));

      pos_in = final_beat ? '0 : pos_ff + POS_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_ok_ff    <= 1'b1;
         searching_ff <= 1'b1;
         sep_idx_ff   <= '0;
         sep_found_ff <= 1'b0;
      end else if (accept) begin
         if (final_beat) begin
            pos_ff       <= '0;
            hdr_ok_ff    <= 1'b1;
            searching_ff <= 1'b1;
            sep_idx_ff   <= '0;
            sep_found_ff <= 1'b0;
         end else begin
            pos_ff       <= pos_in;
            hdr_ok_ff    <= hdr_ok_in;
            searching_ff <= searching_in;
            sep_idx_ff   <= sep_idx_in;
            sep_found_ff <= sep_found_in;
         end
      end
   end

endmodule

>>> hw/rtl/pkcs1_v15_type2_unpad.sv
// ----------------------------------------------------------------------------
// pkcs1_v15_type2_unpad: type 2 encoded message unpadding
// Latency: the first result beat is valid the cycle after the final input beat.
// Throughput: one input beat per cycle; a run emits message_length result beats
//   (at most MAX_MESSAGE_BYTES) at one per cycle while rsp_tready is high, from
//   the output cell chain, and a final input beat waits until the last result
//   beat of the previous run leaves, at the latest in the same cycle.
// Reset: synchronous, active high; clears run state and restores the default
//   lengths, no clear pass.
// ----------------------------------------------------------------------------
module pkcs1_v15_type2_unpad
   import pk1u_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   // input beats
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,  // em_byte, fallback_byte
   // result beats
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,  // message_byte
   output logic                      rsp_tuser,  // padding_valid
   output logic                      rsp_tlast   // last_byte
);

   logic [EM_LEN_WIDTH-1:0]  em_length_ff;
   logic [MSG_LEN_WIDTH-1:0] message_length_ff;

   logic [LEN_WIDTH-1:0]     len;
   logic [MSG_LEN_WIDTH-1:0] mlen;
   logic [BYTE_WIDTH-1:0]    em_byte, fallback_byte;

   parse_status_type         status;
   cell_ctrl_type            cell_ctrl;
   logic                     req_accept, rsp_accept, load;
   logic [COUNT_WIDTH-1:0]   remain_ff;
   logic                     valid_ff;
   logic [CALC_WIDTH-1:0]    short_cnt;
   logic                     is_short;
   logic [BYTE_WIDTH-1:0]    chain [MAX_MESSAGE_BYTES+1];

   assign em_byte       = req_tdata[7:0];
   assign fallback_byte = req_tdata[15:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         em_length_ff      <= EM_LENGTH_RESET;
         message_length_ff <= MESSAGE_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_EM_LENGTH:      em_length_ff      <= csr_wdata;
            CSR_MESSAGE_LENGTH: message_length_ff <= csr_wdata[MSG_LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp lengths to the supported range
   always_comb begin
      if (em_length_ff == '0) begin
         len = LEN_WIDTH'(1);
      end else if (CALC_WIDTH'(em_length_ff) > CALC_WIDTH'(MAX_EM_BYTES)) begin
         len = LEN_WIDTH'(MAX_EM_BYTES);
      end else begin
         len = LEN_WIDTH'(em_length_ff);
      end
      if (CALC_WIDTH'(message_length_ff) > CALC_WIDTH'(MAX_MESSAGE_BYTES)) begin
         mlen = MSG_LEN_WIDTH'(MAX_MESSAGE_BYTES);
      end else begin
         mlen = message_length_ff;
      end
      is_short  = CALC_WIDTH'(mlen) > CALC_WIDTH'(len);
      short_cnt = CALC_WIDTH'(mlen) - CALC_WIDTH'(len);
   end

   pk1u_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .em_byte (em_byte),
      .len     (len),
      .mlen    (mlen),
      .status  (status)
   );

   // a final beat may enter only once the output chain is free to reload
   assign req_tready = !status.final_beat || (remain_ff == '0)
                    || ((remain_ff == COUNT_WIDTH'(1)) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign load       = req_accept && status.final_beat && (mlen != '0);

   assign cell_ctrl.load  = load;
   assign cell_ctrl.shift = rsp_accept && !load;
   assign cell_ctrl.valid = status.run_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else if (load) begin
         remain_ff <= COUNT_WIDTH'(mlen);
         valid_ff  <= status.run_valid;
      end else if (rsp_accept) begin
         remain_ff <= remain_ff - COUNT_WIDTH'(1);
      end
   end

   assign chain[MAX_MESSAGE_BYTES] = '0;

   for (genvar i = 0; i < MAX_MESSAGE_BYTES; i++) begin : g_cell
      logic wr_en;
      logic zero_fill;

      assign wr_en     = req_accept && status.wr_ok
                      && (status.wr_idx == CELL_IDX_WIDTH'(i));
      // positions before the start of a short run read as zero
      assign zero_fill = is_short && (CALC_WIDTH'(i) < short_cnt);

      pk1u_cell u_cell (
         .clock         (clock),
         .ctrl          (cell_ctrl),
         .wr_en         (wr_en),
         .zero_fill     (zero_fill),
         .em_byte       (em_byte),
         .fallback_byte (fallback_byte),
         .chain_in      (chain[i+1]),
         .chain_out     (chain[i])
      );
   end

   assign rsp_tvalid = (remain_ff != '0);
   assign rsp_tdata  = chain[0];
   assign rsp_tuser  = valid_ff;
   assign rsp_tlast  = (remain_ff == COUNT_WIDTH'(1));

endmodule

>>> bench/pkcs1_v15_type2_unpad_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkcs1_v15_type2_unpad_tb: self-checking bench for the type 2 unpadding block
// Streams encoded messages under several length settings, predicts the result
// beats of every run in a scoreboard and compares them beat by beat.
// ----------------------------------------------------------------------------
module pkcs1_v15_type2_unpad_tb
   import pk1u_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          RANDOM_BEATS  = 400;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } result_beat_type;

   typedef enum int {
      CLEAN, BAD_LEAD, BAD_TYPE, EARLY_ZERO, NO_SEPARATOR, NOISE
   } run_flaw_type;

   class unpad_scoreboard;
      logic [EM_LEN_WIDTH-1:0]  em_length_reg;
      logic [MSG_LEN_WIDTH-1:0] msg_length_reg;
      int                       position;
      bit                       header_ok;
      bit                       searching;
      bit                       sep_found;
      int                       sep_index;
      logic [7:0]               msg_store [MAX_MESSAGE_BYTES];
      logic [7:0]               fb_store  [MAX_MESSAGE_BYTES];
      result_beat_type          expected_beats [$];
      int                       mismatches;

      function new();
         em_length_reg  = EM_LENGTH_RESET;
         msg_length_reg = MESSAGE_LENGTH_RESET;
         mismatches     = 0;
         foreach (msg_store[i]) begin
            msg_store[i] = '0;
            fb_store[i]  = '0;
         end
         clear_run();
      endfunction

      function void clear_run();
         position  = 0;
         header_ok = 1'b1;
         searching = 1'b1;
         sep_found = 1'b0;
         sep_index = 0;
      endfunction

      function void write_register(logic [CSR_ADDR_WIDTH-1:0] index, int value);
         if (index == CSR_EM_LENGTH) begin
            em_length_reg = EM_LEN_WIDTH'(value);
         end else begin
            msg_length_reg = MSG_LEN_WIDTH'(value);
         end
      endfunction

      // one accepted input beat; the final beat of a run queues its results
      function void note_input(logic [7:0] em_byte, logic [7:0] fb_byte);
         int              len;
         int              mlen;
         int              idx;
         bit              ok;
         result_beat_type beat;
         len  = em_length_reg;
         mlen = msg_length_reg;
         if (len < 1) len = 1;
         if (len > MAX_EM_BYTES) len = MAX_EM_BYTES;
         if (mlen > MAX_MESSAGE_BYTES) mlen = MAX_MESSAGE_BYTES;
         if (position == 0) begin
            header_ok = header_ok && (em_byte == LEAD_BYTE);
         end else if (position == 1) begin
            header_ok = header_ok && (em_byte == BLOCK_TYPE);
         end else if (searching && em_byte == SEPARATOR) begin
            sep_index = position;
            sep_found = 1'b1;
            searching = 1'b0;
         end
         // tail of the run lands in the message window
         idx = position + mlen - len;
         if (idx >= 0 && idx < mlen) begin
            msg_store[idx] = em_byte;
            fb_store[idx]  = fb_byte;
         end
         if (position < len - 1) begin
            position++;
            return;
         end
         ok = header_ok && sep_found && sep_index >= MIN_SEP_INDEX
            && (len - (sep_index + 1)) == mlen && len >= mlen + MIN_OVERHEAD;
         for (int k = 0; k < mlen; k++) begin
            // positions ahead of a short run read as zero
            if (k < mlen - len) beat.data = '0;
            else beat.data = ok ? msg_store[k] : fb_store[k];
            beat.valid = ok;
            beat.last  = (k == mlen - 1);
            expected_beats.push_back(beat);
         end
         clear_run();
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [7:0] data, logic valid, logic last);
         result_beat_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %02h", data));
            return;
         end
         want = expected_beats.pop_front();
         if (data !== want.data)
            report_mismatch($sformatf("message_byte %02h, want %02h", data, want.data));
         if (valid !== want.valid)
            report_mismatch($sformatf("padding_valid %b, want %b", valid, want.valid));
         if (last !== want.last)
            report_mismatch($sformatf("last_byte %b, want %b", last, want.last));
      endtask
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;  // em_byte, fallback_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;        // message_byte
   logic                      rsp_tuser;        // padding_valid
   logic                      rsp_tlast;        // last_byte

   unpad_scoreboard sb;
   logic [7:0]      em_q [$];
   logic [7:0]      fb_q [$];
   int unsigned     cycle_count   = 0;
   int              beats_sent    = 0;
   int              burst_left    = 0;
   bit              sender_steady = 1'b0;
   int              hold_left     = 0;

   pkcs1_v15_type2_unpad DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("pkcs1_v15_type2_unpad: mismatch");
      $finish;
   end

   // result side: check the beat, then pick the next ready level
   initial begin : receiver
      int mode;
      int span;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 128);
         end
         span--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= span[0];
            endcase
         end
      end
   end

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      // a run without results may still be finishing inside the block
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] index, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_register(index, value);
   endtask

   task automatic configure(input int em_len, input int msg_len);
      wait_drained();
      write_csr(CSR_EM_LENGTH, em_len);
      write_csr(CSR_MESSAGE_LENGTH, msg_len);
   endtask

   task automatic send_queued();
      int gap;
      while (em_q.size() != 0) begin
         if (!sender_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 12);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if (burst_left != 0) burst_left--;
         req_tvalid <= 1'b1;
         req_tdata  <= {fb_q[0], em_q[0]};
         do @(posedge clock); while (!req_tready);
         sb.note_input(em_q[0], fb_q[0]);
         em_q.delete(0);
         fb_q.delete(0);
         beats_sent++;
      end
   endtask

   // a well-formed encoded message, then maybe one flaw on top
   task automatic build_run(input int len, input int mlen);
      int           sep;
      int           pick;
      run_flaw_type flaw;
      logic [7:0]   b;
      sep  = len - mlen - 1;
      pick = $urandom_range(0, 9);
      flaw = (pick < 5) ? CLEAN : run_flaw_type'(pick - 4);
      for (int i = 0; i < len; i++) begin
         if (i == 0) b = LEAD_BYTE;
         else if (i == 1) b = BLOCK_TYPE;
         else if (i < sep) b = 8'($urandom_range(1, 255));
         else if (i == sep) b = SEPARATOR;
         else b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         em_q.push_back(b);
         fb_q.push_back(8'($urandom_range(0, 255)));
      end
      case (flaw)
         BAD_LEAD: em_q[0] = em_q[0] ^ 8'($urandom_range(1, 255));
         BAD_TYPE: if (len > 1) em_q[1] = em_q[1] ^ 8'($urandom_range(1, 255));
         EARLY_ZERO: if (sep > 2) em_q[$urandom_range(2, sep - 1)] = SEPARATOR;
         NO_SEPARATOR: if (sep >= 2) em_q[sep] = 8'($urandom_range(1, 255));
         NOISE: begin
            foreach (em_q[i])
               em_q[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
         end
         default: ;
      endcase
   endtask

   task automatic run_phase(input int em_len, input int msg_len, input int runs,
                            input int hold);
      int len_eff;
      int mlen_eff;
      configure(em_len, msg_len);
      len_eff  = (em_len < 1) ? 1 : (em_len > MAX_EM_BYTES) ? MAX_EM_BYTES : em_len;
      mlen_eff = (msg_len > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : msg_len;
      sender_steady = ($urandom_range(0, 3) == 0);
      hold_left     = hold;
      repeat (runs) begin
         build_run(len_eff, mlen_eff);
         send_queued();
      end
   endtask

   initial begin : stimulus
      int pick;
      int em;
      int mlen;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // shortest valid layout with a message byte, all-ones and zero bytes, zero inside the message
      configure(12, 1);
      em_q = {8'h00, 8'h02, 8'hFF, 8'h01, 8'h80, 8'h7F,
              8'hFE, 8'h55, 8'hAA, 8'h03, 8'h00, 8'h00};
      fb_q = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
              8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
      send_queued();
      // zero lengths: run of one beat that emits nothing
      configure(0, 0);
      em_q = {8'hFF};
      fb_q = {8'hFF};
      send_queued();
      // run shorter than the message
      configure(1, 3);
      em_q = {8'h00};
      fb_q = {8'h5A};
      send_queued();
      // oversized message length clamps, short run again
      configure(5, 127);
      em_q = {8'h00, 8'h02, 8'h00, 8'hFF, 8'h01};
      fb_q = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
      send_queued();

      // long receiver hold-off so the final beat of a later run stalls
      run_phase(40, 24, 4, 300);

      while (beats_sent < RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            mlen = $urandom_range(1, 24);
            em   = mlen + MIN_OVERHEAD + $urandom_range(0, 20);
         end else if (pick == 6) begin
            mlen = $urandom_range(0, 127);
            em   = $urandom_range(0, 30);
         end else if (pick < 9) begin
            mlen = $urandom_range(1, 64);
            em   = mlen + $urandom_range(0, 12);
         end else begin
            mlen = $urandom_range(MAX_MESSAGE_BYTES, 127);
            em   = MAX_MESSAGE_BYTES + MIN_OVERHEAD + $urandom_range(0, 6);
         end
         run_phase(em, mlen, $urandom_range(1, 4), 0);
      end

      wait_drained();
      if (sb.mismatches == 0) begin
         $display("pkcs1_v15_type2_unpad: match");
      end else begin
         $display("pkcs1_v15_type2_unpad: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/pk1u_pkg.sv
hw/rtl/pk1u_cell.sv
hw/rtl/pk1u_ctrl.sv
hw/rtl/pkcs1_v15_type2_unpad.sv
bench/pkcs1_v15_type2_unpad_tb.sv
